@@ src/etf_pkg.sv @@
`timescale 1ns / 1ps

package etf_pkg;

  localparam int IMAGE_WIDTH   = 1024;
  localparam int IMAGE_HEIGHT  = 1024;
  localparam int GRADIENT_LOW  = 0;
  localparam int GRADIENT_HIGH = 16777215;
  localparam int INSIDE_COLOR  = 3394764;

  localparam int FRAC_BITS  = 28;
  localparam int PIX_W      = 10;
  localparam int COLOR_W    = 24;
  localparam int ITER_W     = 12;
  localparam int STEP_W     = PIX_W + 30;
  localparam int GRAD_SPAN  = GRADIENT_HIGH - GRADIENT_LOW;
  localparam bit GRAD_DESC  = (GRAD_SPAN < 0);
  localparam int GRAD_MAG   = GRAD_DESC ? -GRAD_SPAN : GRAD_SPAN;

  localparam logic [COLOR_W-1:0] GradLow     = COLOR_W'(GRADIENT_LOW);
  localparam logic [COLOR_W-1:0] GradSpanAbs = COLOR_W'(GRAD_MAG);
  localparam logic [COLOR_W-1:0] InsideColor = COLOR_W'(INSIDE_COLOR);
  localparam logic signed [63:0] QTwo        = 64'sd2 <<< FRAC_BITS;

  localparam logic [2:0] REG_JULIA_MODE = 3'd0;
  localparam logic [2:0] REG_ZOOM       = 3'd1;
  localparam logic [2:0] REG_OFFSET_RE  = 3'd2;
  localparam logic [2:0] REG_OFFSET_IM  = 3'd3;
  localparam logic [2:0] REG_JULIA_C_RE = 3'd4;
  localparam logic [2:0] REG_JULIA_C_IM = 3'd5;
  localparam logic [2:0] REG_MAX_ITER   = 3'd6;
  localparam logic [2:0] REG_THRESHOLD  = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_RE,
    ST_MAP_IM,
    ST_MAP_END,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_CROSS,
    ST_UPDATE,
    ST_COL_MUL,
    ST_DIV_LOAD,
    ST_DIV,
    ST_DONE
  } etf_state_e;

  function automatic logic signed [31:0] sat_q(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ src/escape_time_fractal_pixel_top.sv @@
`timescale 1ns / 1ps

// Escape-time fractal engine for Mandelbrot and Julia sets. Each pixel word
// is mapped onto the view, then z = z*z + c is iterated in signed Q4.28 on a
// single shared 32x32 multiplier driven by a small sequencer. Mapping runs
// through the states MAP_RE, MAP_IM and MAP_END, and each iteration through
// SQ_RE, SQ_IM, CROSS and UPDATE (three multiplies and an update). An escaping
// point then goes through the colour scaling and a one-bit-per-cycle divide
// by max_iterations. The input side is not ready while a pixel is in work; a
// finished word sits in an output register so the next pixel can be accepted
// while it waits to be taken.
module escape_time_fractal_pixel_top import etf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // pixel_x, pixel_y, zero padding
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_x, out_y, pixel_color, zero padding
  output logic        m_axis_tuser    // escaped
);

  etf_state_e state_q, state_d;

  logic               julia_q;
  logic [30:0]        zoom_q;
  logic signed [31:0] off_re_q, off_im_q, c_re_cfg_q, c_im_cfg_q;
  logic [ITER_W-1:0]  max_iter_q;
  logic [30:0]        thresh_q;

  logic [PIX_W-1:0]   x_q, y_q;
  logic signed [31:0] zr_q, zi_q, cr_q, ci_q;
  logic signed [63:0] prod_q, rr_q, diff_q;
  logic [ITER_W-1:0]  iter_q;
  logic               esc_q;
  logic [ITER_W-1:0]  rem_q;
  logic [COLOR_W-1:0] div_q;
  logic [4:0]         cnt_q;

  logic               m_valid_q;
  logic [PIX_W-1:0]   ox_q, oy_q;
  logic [COLOR_W-1:0] color_q;
  logic               oesc_q;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_d;
  logic               in_acc, out_free, escape_hit;
  logic [STEP_W-1:0]  step_x, step_y;
  logic signed [31:0] base_x, base_y, map_val, zr_next, zi_next;
  logic [63:0]        mag, bound;
  logic [ITER_W-1:0]  esc_idx;
  logic [ITER_W:0]    rem_sh;
  logic [COLOR_W-1:0] grad_color;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  assign step_x = STEP_W'({s_axis_tdata[PIX_W-1:0], 30'd0} / IMAGE_WIDTH);
  assign step_y = STEP_W'({s_axis_tdata[2*PIX_W-1:PIX_W], 30'd0} / IMAGE_HEIGHT);
  assign base_x = sat_q($signed({{(64-STEP_W){1'b0}}, step_x}) - QTwo);
  assign base_y = sat_q(QTwo - $signed({{(64-STEP_W){1'b0}}, step_y}));

  assign map_val = sat_q(64'(sat_q(prod_q >>> FRAC_BITS)) +
                         ((state_q == ST_MAP_IM) ? 64'(off_re_q) : 64'(off_im_q)));

  assign zr_next = sat_q((diff_q >>> FRAC_BITS) + 64'(cr_q));
  assign zi_next = sat_q((prod_q >>> (FRAC_BITS - 1)) + 64'(ci_q));

  assign mag        = 64'(rr_q) + 64'(prod_q);
  assign bound      = {5'd0, thresh_q, 28'd0};
  assign escape_hit = (iter_q != '0) && (mag > bound);
  assign esc_idx    = iter_q - 1'b1;

  assign rem_sh     = {rem_q, div_q[COLOR_W-1]};
  assign grad_color = GRAD_DESC ? (GradLow - div_q) : (GradLow + div_q);

  assign prod_d = mul_a * mul_b;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_acc) state_d = ST_MAP_RE;
      ST_MAP_RE:   state_d = ST_MAP_IM;
      ST_MAP_IM:   state_d = ST_MAP_END;
      ST_MAP_END:  state_d = ST_SQ_RE;
      ST_SQ_RE:    state_d = ST_SQ_IM;
      ST_SQ_IM:    state_d = ST_CROSS;
      ST_CROSS: begin
        priority if (escape_hit) state_d = ST_COL_MUL;
        else if (iter_q == max_iter_q) state_d = ST_DONE;
        else state_d = ST_UPDATE;
      end
      ST_UPDATE:   state_d = ST_SQ_RE;
      ST_COL_MUL:  state_d = ST_DIV_LOAD;
      ST_DIV_LOAD: state_d = ST_DIV;
      ST_DIV:      if (cnt_q == 5'(COLOR_W - 1)) state_d = ST_DONE;
      ST_DONE:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    unique case (state_q)
      ST_IDLE:    s_axis_tready = 1'b1;
      ST_MAP_RE: begin
        mul_a = zr_q;
        mul_b = $signed({1'b0, zoom_q});
      end
      ST_MAP_IM: begin
        mul_a = zi_q;
        mul_b = $signed({1'b0, zoom_q});
      end
      ST_SQ_RE: begin
        mul_a = zr_q;
        mul_b = zr_q;
      end
      ST_SQ_IM: begin
        mul_a = zi_q;
        mul_b = zi_q;
      end
      ST_CROSS: begin
        mul_a = zr_q;
        mul_b = zi_q;
      end
      ST_COL_MUL: begin
        mul_a = $signed({{(32-COLOR_W){1'b0}}, GradSpanAbs});
        mul_b = $signed({{(32-ITER_W){1'b0}}, esc_idx});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      julia_q    <= 1'b0;
      zoom_q     <= 31'h1000_0000;
      off_re_q   <= '0;
      off_im_q   <= '0;
      c_re_cfg_q <= '0;
      c_im_cfg_q <= '0;
      max_iter_q <= ITER_W'(100);
      thresh_q   <= 31'h4000_0000;
      m_valid_q  <= 1'b0;
      iter_q     <= '0;
      cnt_q      <= '0;
      esc_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_JULIA_MODE: julia_q    <= cfg_data_i[0];
          REG_ZOOM:       zoom_q     <= cfg_data_i[30:0];
          REG_OFFSET_RE:  off_re_q   <= cfg_data_i;
          REG_OFFSET_IM:  off_im_q   <= cfg_data_i;
          REG_JULIA_C_RE: c_re_cfg_q <= cfg_data_i;
          REG_JULIA_C_IM: c_im_cfg_q <= cfg_data_i;
          REG_MAX_ITER:   max_iter_q <= cfg_data_i[ITER_W-1:0];
          REG_THRESHOLD:  thresh_q   <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        iter_q <= '0;
        esc_q  <= 1'b0;
      end
      if (state_q == ST_UPDATE) iter_q <= iter_q + 1'b1;
      if (state_q == ST_CROSS && escape_hit) esc_q <= 1'b1;
      if (state_q == ST_DIV_LOAD) cnt_q <= '0;
      if (state_q == ST_DIV) cnt_q <= cnt_q + 1'b1;
      if (state_q == ST_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          x_q  <= s_axis_tdata[PIX_W-1:0];
          y_q  <= s_axis_tdata[2*PIX_W-1:PIX_W];
          zr_q <= base_x;
          zi_q <= base_y;
        end
      end
      ST_MAP_IM:  zr_q <= map_val;
      ST_MAP_END: begin
        zi_q <= map_val;
        cr_q <= julia_q ? c_re_cfg_q : zr_q;
        ci_q <= julia_q ? c_im_cfg_q : map_val;
      end
      ST_SQ_IM:   rr_q <= prod_q;
      ST_CROSS:   diff_q <= rr_q - prod_q;
      ST_UPDATE: begin
        zr_q <= zr_next;
        zi_q <= zi_next;
      end
      ST_DIV_LOAD: begin
        rem_q <= prod_q[COLOR_W+ITER_W-1:COLOR_W];
        div_q <= prod_q[COLOR_W-1:0];
      end
      ST_DIV: begin
        if (rem_sh >= {1'b0, max_iter_q}) begin
          rem_q <= ITER_W'(rem_sh - {1'b0, max_iter_q});
          div_q <= {div_q[COLOR_W-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[ITER_W-1:0];
          div_q <= {div_q[COLOR_W-2:0], 1'b0};
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ox_q    <= x_q;
          oy_q    <= y_q;
          color_q <= esc_q ? grad_color : InsideColor;
          oesc_q  <= esc_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'd0, color_q, oy_q, ox_q};
  assign m_axis_tuser  = oesc_q;

endmodule

@@ src/etf_checker.sv @@
`timescale 1ns / 1ps

module etf_checker import etf_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // A stalled result word holds still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // Only one pixel is in work at a time.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("input accepted again while busy");

  // Mapping comes before any result, so m_axis_tvalid does not rise right on an accept.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

  // A point that did not escape carries the inside colour.
  a_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[43:20] == InsideColor)
    else $error("inside point with wrong colour");

endmodule

bind escape_time_fractal_pixel_top etf_checker u_etf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
